// ===== design/cts_pkg.sv =====
`timescale 1ns / 1ps
package cts_pkg;

   // Widths sized for the largest supported configuration
   localparam int LAYER_W = 4;
   localparam int COORD_W = 10;
   localparam int SPAN_W  = 11;
   localparam int CIDX_W  = 8;
   localparam int COFF_W  = 6;
   localparam int TILEV_W = 32;
   localparam int CALC_W  = 14;

   localparam logic [1:0] REQ_SET   = 2'd0;
   localparam logic [1:0] REQ_GET   = 2'd1;
   localparam logic [1:0] REQ_FILL  = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_LAYERS     = 2'd2;

   typedef enum logic [2:0] {
      OP_SET,
      OP_GET,
      OP_FILL,
      OP_CLEAR,
      OP_REJECT
   } op_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_ISSUE,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type               op;
      logic [LAYER_W-1:0]   layer;
      logic [COORD_W-1:0]   x0;
      logic [COORD_W-1:0]   y0;
      logic [SPAN_W-1:0]    cols;
      logic [SPAN_W-1:0]    rows;
      logic [CIDX_W-1:0]    cx;
      logic [CIDX_W-1:0]    cy;
      logic [COFF_W-1:0]    ox;
      logic [COFF_W-1:0]    oy;
      logic [TILEV_W-1:0]   tile;
   } cmd_type;

endpackage

// ===== design/cts_queue.sv =====
`timescale 1ns / 1ps
module cts_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cts_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output cts_pkg::cmd_type out_cmd
);

   cts_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== design/cts_front.sv =====
`timescale 1ns / 1ps
module cts_front #(
   parameter int MAX_LAYERS  = 4,
   parameter int CHUNK_DIM   = 32,
   parameter int MAP_DIM_MAX = 128,
   parameter int TILE_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_type,
   input  logic [2:0]            req_layer_index,
   input  logic signed [10:0]    req_pos_x,
   input  logic signed [10:0]    req_pos_y,
   input  logic [10:0]           req_fill_width,
   input  logic [10:0]           req_fill_height,
   input  logic [TILE_BITS-1:0]  req_tile_value,
   input  logic                  init_done,
   output logic                  push_valid,
   input  logic                  push_ready,
   output cts_pkg::cmd_type      push_cmd
);

   localparam int CHUNKS_SIDE = (MAP_DIM_MAX + CHUNK_DIM - 1) / CHUNK_DIM;
   localparam int CW = cts_pkg::CALC_W;

   logic [7:0] map_width_ff, map_width_in;
   logic [7:0] map_height_ff, map_height_in;
   logic [2:0] layers_ff, layers_in;

   assign csr_ready  = 1'b1;
   assign req_ready  = init_done && push_ready;
   assign push_valid = req_valid && init_done;

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      layers_in     = layers_ff;
      if (csr_valid) begin
         case (csr_index)
            cts_pkg::CSR_MAP_WIDTH:  map_width_in  = csr_wdata;
            cts_pkg::CSR_MAP_HEIGHT: map_height_in = csr_wdata;
            cts_pkg::CSR_LAYERS:     layers_in     = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= 8'd128;
         map_height_ff <= 8'd128;
         layers_ff     <= 3'd0;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         layers_ff     <= layers_in;
      end
   end

   always_comb begin
      logic signed [CW-1:0] mw, mh, xs, ys, xe, ye, x0, y0, x1, y1;
      logic [4:0]           lay_lim;
      logic                 layer_ok, in_map, nonempty;
      logic [cts_pkg::COORD_W-1:0] x0u, y0u;
      logic [cts_pkg::CIDX_W-1:0]  cx, cy;

      mw = (int'(map_width_ff) > MAP_DIM_MAX) ? CW'(MAP_DIM_MAX) : CW'(map_width_ff);
      mh = (int'(map_height_ff) > MAP_DIM_MAX) ? CW'(MAP_DIM_MAX) : CW'(map_height_ff);
      xs = CW'(req_pos_x);
      ys = CW'(req_pos_y);
      xe = xs + $signed({3'b000, req_fill_width});
      ye = ys + $signed({3'b000, req_fill_height});
      x0 = (xs < 0) ? '0 : xs;
      y0 = (ys < 0) ? '0 : ys;
      x1 = (xe > mw) ? mw : xe;
      y1 = (ye > mh) ? mh : ye;

      lay_lim  = (int'(layers_ff) > MAX_LAYERS) ? 5'(MAX_LAYERS) : {2'b00, layers_ff};
      layer_ok = ({2'b00, req_layer_index} < lay_lim);
      in_map   = (xs >= 0) && (ys >= 0) && (xs < mw) && (ys < mh);
      nonempty = (x1 > x0) && (y1 > y0);

      x0u = x0[cts_pkg::COORD_W-1:0];
      y0u = y0[cts_pkg::COORD_W-1:0];

      // chunk coordinates of the start tile
      cx = '0;
      cy = '0;
      for (int k = 1; k < CHUNKS_SIDE; k++) begin
         if (int'(x0u) >= k * CHUNK_DIM) cx = cts_pkg::CIDX_W'(k);
         if (int'(y0u) >= k * CHUNK_DIM) cy = cts_pkg::CIDX_W'(k);
      end

      push_cmd.layer = {1'b0, req_layer_index};
      push_cmd.x0    = x0u;
      push_cmd.y0    = y0u;
      push_cmd.cols  = cts_pkg::SPAN_W'(x1 - x0);
      push_cmd.rows  = cts_pkg::SPAN_W'(y1 - y0);
      push_cmd.cx    = cx;
      push_cmd.cy    = cy;
      push_cmd.ox    = cts_pkg::COFF_W'(int'(x0u) - int'(cx) * CHUNK_DIM);
      push_cmd.oy    = cts_pkg::COFF_W'(int'(y0u) - int'(cy) * CHUNK_DIM);
      push_cmd.tile  = cts_pkg::TILEV_W'(req_tile_value);

      case (req_type)
         cts_pkg::REQ_SET:   push_cmd.op = (layer_ok && in_map) ? cts_pkg::OP_SET
                                                                : cts_pkg::OP_REJECT;
         cts_pkg::REQ_GET:   push_cmd.op = (layer_ok && in_map) ? cts_pkg::OP_GET
                                                                : cts_pkg::OP_REJECT;
         cts_pkg::REQ_FILL:  push_cmd.op = (layer_ok && nonempty) ? cts_pkg::OP_FILL
                                                                  : cts_pkg::OP_REJECT;
         cts_pkg::REQ_CLEAR: push_cmd.op = layer_ok ? cts_pkg::OP_CLEAR : cts_pkg::OP_REJECT;
         default:            push_cmd.op = cts_pkg::OP_REJECT;
      endcase
   end

endmodule

// ===== design/cts_back.sv =====
`timescale 1ns / 1ps
module cts_back #(
   parameter int MAX_LAYERS  = 4,
   parameter int CHUNK_DIM   = 32,
   parameter int MAP_DIM_MAX = 128,
   parameter int TILE_BITS   = 16,
   parameter int CNT_W       = $clog2(CHUNK_DIM * CHUNK_DIM + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  cts_pkg::cmd_type     q_cmd,
   output logic                 init_done,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TILE_BITS-1:0] rsp_read_tile,
   output logic                 rsp_status,
   output logic [CNT_W-1:0]     rsp_chunk_occupancy
);

   localparam int CS    = (MAP_DIM_MAX + CHUNK_DIM - 1) / CHUNK_DIM;
   localparam int CPL   = CS * CS;
   localparam int TPL   = MAP_DIM_MAX * MAP_DIM_MAX;
   localparam int TDEP  = MAX_LAYERS * TPL;
   localparam int CDEP  = MAX_LAYERS * CPL;
   localparam int TA_W  = $clog2(TDEP);
   localparam int CA_W  = (CDEP > 1) ? $clog2(CDEP) : 1;
   localparam int TL_W  = TA_W + 1;
   localparam int CL_W  = CA_W + 1;
   localparam int SW    = cts_pkg::SPAN_W;
   localparam int OW    = cts_pkg::COFF_W;

   logic [TILE_BITS-1:0] tile_mem [TDEP];
   logic [CNT_W-1:0]     cnt_mem  [CDEP];

   cts_pkg::state_type state_ff, state_in;
   cts_pkg::cmd_type   cmd_ff, cmd_in;
   logic [TA_W-1:0]    taddr_ff, taddr_in, row_taddr_ff, row_taddr_in;
   logic [CA_W-1:0]    caddr_ff, caddr_in, row_caddr_ff, row_caddr_in;
   logic [TL_W-1:0]    tleft_ff, tleft_in;
   logic [CL_W-1:0]    cleft_ff, cleft_in;
   logic [SW-1:0]      cols_ff, cols_in, rows_ff, rows_in;
   logic [OW-1:0]      ox_ff, ox_in, oy_ff, oy_in;
   logic               init_done_ff, init_done_in;
   logic [TILE_BITS-1:0] res_tile_ff, res_tile_in;
   logic               res_status_ff, res_status_in;
   logic [CNT_W-1:0]   res_occ_ff, res_occ_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TILE_BITS-1:0] rsp_tile_ff, rsp_tile_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]   rsp_occ_ff, rsp_occ_in;

   logic [TILE_BITS-1:0] tile_rd_ff;
   logic [CNT_W-1:0]     cnt_rd_ff;
   logic                 tile_we, cnt_we;
   logic [TILE_BITS-1:0] tile_wdata;
   logic [CNT_W-1:0]     cnt_wdata, new_cnt;
   logic                 out_free;

   assign init_done           = init_done_ff;
   assign q_ready             = (state_ff == cts_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_tile       = rsp_tile_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_chunk_occupancy = rsp_occ_ff;
   assign out_free            = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic [TILE_BITS-1:0] nt;
      nt = TILE_BITS'(cmd_ff.tile);
      if ((tile_rd_ff == '0) && (nt != '0))      new_cnt = cnt_rd_ff + 1'b1;
      else if ((tile_rd_ff != '0) && (nt == '0)) new_cnt = cnt_rd_ff - 1'b1;
      else                                       new_cnt = cnt_rd_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cts_pkg::ST_SWEEP:
            if (tleft_ff == TL_W'(1)) state_in = init_done_ff ? cts_pkg::ST_DONE
                                                              : cts_pkg::ST_IDLE;
         cts_pkg::ST_IDLE:
            if (q_valid) begin
               case (q_cmd.op)
                  cts_pkg::OP_CLEAR: state_in = cts_pkg::ST_SWEEP;
                  cts_pkg::OP_REJECT: state_in = cts_pkg::ST_DONE;
                  default:           state_in = cts_pkg::ST_ISSUE;
               endcase
            end
         cts_pkg::ST_ISSUE:  state_in = cts_pkg::ST_UPDATE;
         cts_pkg::ST_UPDATE:
            if (cmd_ff.op == cts_pkg::OP_FILL && !(cols_ff == SW'(1) && rows_ff == SW'(1)))
               state_in = cts_pkg::ST_ISSUE;
            else
               state_in = cts_pkg::ST_DONE;
         cts_pkg::ST_DONE:
            if (out_free) state_in = cts_pkg::ST_IDLE;
         default: state_in = cts_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in        = cmd_ff;
      taddr_in      = taddr_ff;
      row_taddr_in  = row_taddr_ff;
      caddr_in      = caddr_ff;
      row_caddr_in  = row_caddr_ff;
      tleft_in      = tleft_ff;
      cleft_in      = cleft_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      init_done_in  = init_done_ff;
      res_tile_in   = res_tile_ff;
      res_status_in = res_status_ff;
      res_occ_in    = res_occ_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_tile_in   = rsp_tile_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      tile_we       = 1'b0;
      cnt_we        = 1'b0;
      tile_wdata    = '0;
      cnt_wdata     = '0;

      case (state_ff)
         cts_pkg::ST_SWEEP: begin
            tile_we  = 1'b1;
            cnt_we   = (cleft_ff != '0);
            taddr_in = taddr_ff + 1'b1;
            tleft_in = tleft_ff - 1'b1;
            if (cleft_ff != '0) begin
               caddr_in = caddr_ff + 1'b1;
               cleft_in = cleft_ff - 1'b1;
            end
            if (tleft_ff == TL_W'(1)) init_done_in = 1'b1;
         end
         cts_pkg::ST_IDLE: begin
            if (q_valid) begin
               cmd_in        = q_cmd;
               res_tile_in   = '0;
               res_status_in = (q_cmd.op == cts_pkg::OP_REJECT);
               res_occ_in    = '0;
               cols_in       = q_cmd.cols;
               rows_in       = q_cmd.rows;
               ox_in         = q_cmd.ox;
               oy_in         = q_cmd.oy;
               if (q_cmd.op == cts_pkg::OP_CLEAR) begin
                  taddr_in = TA_W'(int'(q_cmd.layer) * TPL);
                  caddr_in = CA_W'(int'(q_cmd.layer) * CPL);
                  tleft_in = TL_W'(TPL);
                  cleft_in = CL_W'(CPL);
               end else begin
                  taddr_in = TA_W'(int'(q_cmd.layer) * TPL
                                   + int'(q_cmd.y0) * MAP_DIM_MAX + int'(q_cmd.x0));
                  caddr_in = CA_W'(int'(q_cmd.layer) * CPL
                                   + int'(q_cmd.cy) * CS + int'(q_cmd.cx));
               end
               row_taddr_in = taddr_in;
               row_caddr_in = caddr_in;
            end
         end
         cts_pkg::ST_ISSUE: ;
         cts_pkg::ST_UPDATE: begin
            case (cmd_ff.op)
               cts_pkg::OP_GET: begin
                  res_tile_in = tile_rd_ff;
                  res_occ_in  = cnt_rd_ff;
               end
               cts_pkg::OP_SET: begin
                  tile_we    = 1'b1;
                  cnt_we     = 1'b1;
                  tile_wdata = TILE_BITS'(cmd_ff.tile);
                  cnt_wdata  = new_cnt;
                  res_occ_in = new_cnt;
               end
               cts_pkg::OP_FILL: begin
                  tile_we    = 1'b1;
                  cnt_we     = 1'b1;
                  tile_wdata = TILE_BITS'(cmd_ff.tile);
                  cnt_wdata  = new_cnt;
                  if (cols_ff != SW'(1)) begin
                     taddr_in = taddr_ff + 1'b1;
                     cols_in  = cols_ff - 1'b1;
                     if (int'(ox_ff) == CHUNK_DIM - 1) begin
                        ox_in    = '0;
                        caddr_in = caddr_ff + 1'b1;
                     end else begin
                        ox_in = ox_ff + 1'b1;
                     end
                  end else begin
                     // wrap to the start of the next row
                     taddr_in     = TA_W'(int'(row_taddr_ff) + MAP_DIM_MAX);
                     row_taddr_in = taddr_in;
                     cols_in      = cmd_ff.cols;
                     rows_in      = rows_ff - 1'b1;
                     ox_in        = cmd_ff.ox;
                     if (int'(oy_ff) == CHUNK_DIM - 1) begin
                        oy_in        = '0;
                        row_caddr_in = CA_W'(int'(row_caddr_ff) + CS);
                     end else begin
                        oy_in = oy_ff + 1'b1;
                     end
                     caddr_in = row_caddr_in;
                  end
               end
               default: ;
            endcase
         end
         cts_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_tile_in   = res_tile_ff;
               rsp_status_in = res_status_ff;
               rsp_occ_in    = res_occ_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tile_we) tile_mem[taddr_ff] <= tile_wdata;
      tile_rd_ff <= tile_mem[taddr_ff];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[caddr_ff] <= cnt_wdata;
      cnt_rd_ff <= cnt_mem[caddr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cts_pkg::ST_SWEEP;
         taddr_ff     <= '0;
         caddr_ff     <= '0;
         tleft_ff     <= TL_W'(TDEP);
         cleft_ff     <= CL_W'(CDEP);
         init_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taddr_ff     <= taddr_in;
         caddr_ff     <= caddr_in;
         tleft_ff     <= tleft_in;
         cleft_ff     <= cleft_in;
         init_done_ff <= init_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      row_taddr_ff  <= row_taddr_in;
      row_caddr_ff  <= row_caddr_in;
      cols_ff       <= cols_in;
      rows_ff       <= rows_in;
      ox_ff         <= ox_in;
      oy_ff         <= oy_in;
      res_tile_ff   <= res_tile_in;
      res_status_ff <= res_status_in;
      res_occ_ff    <= res_occ_in;
      rsp_tile_ff   <= rsp_tile_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

endmodule

// ===== design/chunked_tile_store_core.sv =====
`timescale 1ns / 1ps
// Layered 2D tile store in square chunks, with a non-empty count per chunk.
// Channels: req_* carries one request item (set, get, fill, clear), rsp_*
// returns exactly one result item per request, in order. csr_* writes
// map_width (index 0), map_height (index 1) and layers_in_use (index 2);
// csr_ready is always high. Write registers only while the block is idle.
// Reset: after reset is released the block zeroes the whole tile and count
// memories, one tile per cycle, MAX_LAYERS*MAP_DIM_MAX*MAP_DIM_MAX tiles
// (65536 at the defaults); req_ready stays low until then.
// Items are taken in IDLE and answered from DONE; a rejected item goes
// straight there. Set and get pass once through ISSUE and UPDATE, fill
// once per tile; clear sweeps the tile and count memory of its layer.
// Items are processed one at a time; a two-entry queue lets req accept
// ahead while the back end works. A stalled rsp holds its item in the
// output register; the back end finishes the next item and waits there.
module chunked_tile_store_core #(
   parameter int MAX_LAYERS  = 4,
   parameter int CHUNK_DIM   = 32,
   parameter int MAP_DIM_MAX = 128,
   parameter int TILE_BITS   = 16,
   parameter int CNT_W       = $clog2(CHUNK_DIM * CHUNK_DIM + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [2:0]           req_layer_index,
   input  logic signed [10:0]   req_pos_x,
   input  logic signed [10:0]   req_pos_y,
   input  logic [10:0]          req_fill_width,
   input  logic [10:0]          req_fill_height,
   input  logic [TILE_BITS-1:0] req_tile_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TILE_BITS-1:0] rsp_read_tile,
   output logic                 rsp_status,
   output logic [CNT_W-1:0]     rsp_chunk_occupancy
);

   cts_pkg::cmd_type push_cmd, pop_cmd;
   logic             push_valid, push_ready, pop_valid, pop_ready, init_done;

   cts_front #(
      .MAX_LAYERS  (MAX_LAYERS),
      .CHUNK_DIM   (CHUNK_DIM),
      .MAP_DIM_MAX (MAP_DIM_MAX),
      .TILE_BITS   (TILE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_layer_index (req_layer_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_fill_width  (req_fill_width),
      .req_fill_height (req_fill_height),
      .req_tile_value  (req_tile_value),
      .init_done       (init_done),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_cmd        (push_cmd)
   );

   cts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_cmd    (push_cmd),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_cmd   (pop_cmd)
   );

   cts_back #(
      .MAX_LAYERS  (MAX_LAYERS),
      .CHUNK_DIM   (CHUNK_DIM),
      .MAP_DIM_MAX (MAP_DIM_MAX),
      .TILE_BITS   (TILE_BITS),
      .CNT_W       (CNT_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (pop_valid),
      .q_ready             (pop_ready),
      .q_cmd               (pop_cmd),
      .init_done           (init_done),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_tile       (rsp_read_tile),
      .rsp_status          (rsp_status),
      .rsp_chunk_occupancy (rsp_chunk_occupancy)
   );

endmodule
